// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every rising edge outside of reset.
`define SLID_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside of reset.
`define SLID_NEVER(label, clk, rst_n, cond) \
    `SLID_ASSERT(label, clk, rst_n, !(cond))

`endif

// File: rtl/slid_pkg.sv
// Shared types and constants of the sorted list store.
// Used by every module of the block; depends on nothing.
package slid_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // What one cell shows to its right neighbor.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      lt;
    } t_tap;

    // Update commands broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } t_cell_ctl;

endpackage

// File: rtl/slid_cell.sv
// One slot of the sorted store: holds a value and shifts it left or right.
// Depends on slid_pkg.
module slid_cell
    import slid_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic                      i_occupied,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_tap                      i_left,
    input  logic signed [VALUE_W-1:0] i_right_value,
    output t_tap                      o_tap,
    output logic                      o_eq
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_lt;

    assign w_lt  = i_occupied && (r_value < i_value);
    assign o_eq  = i_occupied && (r_value == i_value);
    assign o_tap = '{value: r_value, lt: w_lt};

    // Slots below the target keep their value; the target takes the new value
    // on insert and every slot from the target upward moves by one.
    always_comb begin
        n_value = r_value;
        priority if (i_ctl.ins_en && !w_lt) begin
            n_value = i_left.lt ? i_value : i_left.value;
        end else if (i_ctl.del_en && !w_lt) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: rtl/sorted_list_insert_delete_top.sv
// Sorted store of signed values built as a row of compare-and-shift cells.
// A result is valid in the cycle after its request is accepted.
// One request per cycle while each result is taken; every cell compares and shifts at once.
// Reset clears the entry count and the result register; the stored values
// are not cleared, since slots at or above the count never take part in a compare.
module sorted_list_insert_delete_top
    import slid_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_operation,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [2:0]                o_status,
    output logic [ENTRY_W-1:0]        o_entry_count
);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic               w_accept;
    logic               w_full;
    logic               w_found;
    t_cell_ctl          w_ctl;
    t_tap               w_tap  [CAPACITY+1];
    logic signed [VALUE_W-1:0] w_right [CAPACITY];
    logic [CAPACITY-1:0] w_eq;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == COUNT_W'(CAPACITY));
    assign w_found    = |w_eq;

    assign w_ctl.ins_en = w_accept && (i_operation == OP_INSERT) && !w_full;
    assign w_ctl.del_en = w_accept && (i_operation == OP_DELETE) && w_found;

    // The first cell sees a left neighbor that is always smaller.
    assign w_tap[0] = '{value: '0, lt: 1'b1};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = w_tap[g+1].value;
        end else begin : g_mid
            assign w_right[g] = w_tap[g+2].value;
        end

        slid_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (COUNT_W'(g) < r_count),
            .i_value       (i_value),
            .i_left        (w_tap[g]),
            .i_right_value (w_right[g]),
            .o_tap         (w_tap[g+1]),
            .o_eq          (w_eq[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_INSERTED;
        unique case (i_operation)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_count  = r_count + COUNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_status = ST_DELETED;
                    n_count  = r_count - COUNT_W'(1);
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_INSERTED;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = ENTRY_W'(r_count);

endmodule

// File: rtl/slid_checker.sv
// Port-level checks of the sorted list store, bound to the top level.
// Depends on slid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slid_checker
    import slid_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         o_status,
    input logic [ENTRY_W-1:0] o_entry_count
);

    `SLID_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status) && $stable(o_entry_count)))
    `SLID_ASSERT(a_result_follows, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> o_out_valid)
    `SLID_ASSERT(a_full_count, i_clk, i_rst_n, (o_out_valid && o_status == ST_FULL) |-> (o_entry_count == ENTRY_W'(CAPACITY)))
    `SLID_ASSERT(a_empty_count, i_clk, i_rst_n, (o_out_valid && o_status == ST_EMPTY) |-> (o_entry_count == '0))
    `SLID_NEVER(a_status_code, i_clk, i_rst_n, o_out_valid && o_status > ST_EMPTY)

endmodule

bind sorted_list_insert_delete_top slid_checker u_slid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_list_insert_delete_top: directed and random requests.
// Depends on slid_pkg and the RTL of the block; a queue-based shadow list predicts results.

class list_scoreboard;
    logic signed [slid_pkg::VALUE_W-1:0] held_values[$];
    slid_pkg::t_status                   want_status[$];
    logic [slid_pkg::ENTRY_W-1:0]        want_count[$];
    int unsigned                         fail_count;

    function new();
        fail_count = 0;
    endfunction

    function int pending();
        return want_status.size();
    endfunction

    // Applies an accepted request to the shadow list and queues its outcome.
    function void note_request(slid_pkg::t_op op, logic signed [slid_pkg::VALUE_W-1:0] v);
        int                pos;
        slid_pkg::t_status st;
        pos = 0;
        if (op == slid_pkg::OP_INSERT) begin
            if (held_values.size() >= slid_pkg::CAPACITY) begin
                st = slid_pkg::ST_FULL;
            end else begin
                // Equal values stop the scan, so the new one goes ahead of them.
                while (pos < held_values.size() && v > held_values[pos])
                    pos++;
                held_values.insert(pos, v);
                st = slid_pkg::ST_INSERTED;
            end
        end else begin
            if (held_values.size() == 0) begin
                st = slid_pkg::ST_EMPTY;
            end else begin
                while (pos < held_values.size() && held_values[pos] !== v)
                    pos++;
                if (pos == held_values.size()) begin
                    st = slid_pkg::ST_NOT_FOUND;
                end else begin
                    held_values.delete(pos);
                    st = slid_pkg::ST_DELETED;
                end
            end
        end
        want_status.push_back(st);
        want_count.push_back(slid_pkg::ENTRY_W'(held_values.size()));
    endfunction

    function void check_result(logic [2:0] status, logic [slid_pkg::ENTRY_W-1:0] count);
        slid_pkg::t_status            exp_status;
        logic [slid_pkg::ENTRY_W-1:0] exp_count;
        if (want_status.size() == 0) begin
            $error("result with no request outstanding: status %0d entry_count %0d",
                   status, count);
            fail_count++;
            return;
        end
        exp_status = want_status.pop_front();
        exp_count  = want_count.pop_front();
        if (status !== exp_status) begin
            $error("status: expected %0d, actual %0d", exp_status, status);
            fail_count++;
        end
        if (count !== exp_count) begin
            $error("entry_count: expected %0d, actual %0d", exp_count, count);
            fail_count++;
        end
    endfunction
endclass

module tb;
    import slid_pkg::*;

    localparam int RANDOM_REQUESTS = 550;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    logic                      req_operation = 1'b0;
    logic signed [VALUE_W-1:0] req_value = '0;
    logic                      rsp_valid;
    logic                      rsp_ready = 1'b0;
    logic [2:0]                rsp_status;
    logic [ENTRY_W-1:0]        rsp_entry_count;

    int unsigned    send_idle_pct = 7;
    int unsigned    recv_stall_pct = 80;
    list_scoreboard board;

    sorted_list_insert_delete_top uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .o_in_ready    (req_ready),
        .i_operation   (req_operation),
        .i_value       (req_value),
        .o_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .o_status      (rsp_status),
        .o_entry_count (rsp_entry_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // Valid may stay high from one request into the next; it drops only on an idle cycle.
    task automatic send_request(t_op op, logic signed [VALUE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid     <= 1'b1;
        req_operation <= op;
        req_value     <= v;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(op, v);
    endtask

    // Mix of wide random values, a small range, extreme values and stored values so deletes often hit.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned pick;
        int          small_val;
        pick = $urandom_range(0, 9);
        if (pick <= 2)
            return $urandom;
        if (pick <= 4) begin
            small_val = int'($urandom_range(0, 8)) - 4;
            return small_val;
        end
        if (pick == 5) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (board.held_values.size() == 0)
            return $urandom;
        return board.held_values[$urandom_range(0, board.held_values.size() - 1)];
    endfunction

    initial begin
        forever begin
            @(negedge clk);
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                board.check_result(rsp_status, rsp_entry_count);
        end
    end

    initial begin
        int unsigned insert_pct;
        t_op         op;
        board = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty delete, extremes, duplicate zeros, miss, fill to full, delete extremes.
        send_request(OP_DELETE, 32'sd0);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h7fff_ffff);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_DELETE, 32'sd0);
        send_request(OP_DELETE, 32'sd7);
        repeat (CAPACITY - 4) send_request(OP_INSERT, $urandom);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_DELETE, 32'h7fff_ffff);
        send_request(OP_DELETE, 32'h8000_0000);

        insert_pct = 70;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 3) begin
                send_idle_pct  = 80;
                recv_stall_pct = 7;
            end else if (i == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // Alternate fill-heavy and drain-heavy stretches so both full and empty recur.
            if (i % 60 == 0)
                insert_pct = (insert_pct == 70) ? 30 : 70;
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            send_request(op, pick_value());
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.fail_count == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
